@@ hw/rtl/dns_pkg.sv @@
package dns_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Fixed field widths.
  localparam int RADIUS_BITS = 6;
  localparam int START_BITS  = 12;
  localparam int FIELD_BITS  = 16;
  localparam logic [FIELD_BITS-1:0] FIELD_MASK = 16'hFFFF;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RADIUS      = 3'd0,
    REG_CENTER_U    = 3'd1,
    REG_CENTER_V    = 3'd2,
    REG_MIN_U       = 3'd3,
    REG_MAX_U       = 3'd4,
    REG_MIN_V       = 3'd5,
    REG_MAX_V       = 3'd6,
    REG_START_INDEX = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_BUILD,
    ST_IDLE,
    ST_MOD,
    ST_SEED,
    ST_SCAN,
    ST_DELIVER
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_we;
    logic build_init;
    logic build_step;
    logic accept;
    logic mod_step;
    logic seed;
    logic scan_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic build_last;
    logic mod_last;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

@@ hw/rtl/dns_ctrl.sv @@
module dns_ctrl import dns_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  stat_t                   stat,
  output cmd_t                    cmd
);

  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   cfg_fire;
  logic   radius_write;

  assign in_fire      = in_valid && !in_stall;
  assign cfg_fire     = cfg_valid && cfg_ready;
  assign radius_write = cfg_fire && (cfg_reg_t'(cfg_index) == REG_RADIUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        state_next = ST_BUILD;
      end
      ST_BUILD: begin
        if (stat.build_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (radius_write) begin
          state_next = ST_INIT;
        end else if (in_fire) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (stat.mod_last) state_next = ST_SEED;
      end
      ST_SEED: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // A request waits while a configuration beat is offered, so a request and a
  // register write never land on the same edge.
  always_comb begin
    in_stall       = (state != ST_IDLE) || cfg_valid;
    cfg_ready      = (state == ST_IDLE);
    cmd            = '0;
    cmd.cfg_we     = cfg_fire;
    cmd.accept     = in_fire;
    case (state)
      ST_INIT:    cmd.build_init = 1'b1;
      ST_BUILD:   cmd.build_step = 1'b1;
      ST_MOD:     cmd.mod_step   = 1'b1;
      ST_SEED:    cmd.seed       = 1'b1;
      ST_SCAN:    cmd.scan_step  = 1'b1;
      ST_DELIVER: cmd.out_load   = stat.out_free;
      default:    cmd.build_init = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/dns_datapath.sv @@
module dns_datapath import dns_pkg::*; #(
  parameter int RADIUS_CAP = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     restart,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic                     found,
  output logic [FIELD_BITS-1:0]    cell_u,
  output logic [FIELD_BITS-1:0]    cell_v
);

  localparam int DEPTH = 2 * RADIUS_CAP * RADIUS_CAP + 2 * RADIUS_CAP + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DEPTH + 1);
  localparam int DW    = $clog2(RADIUS_CAP + 1) + 1;
  localparam int CW    = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam int SCW   = CW + 2;
  localparam int MCW   = $clog2(START_BITS);

  // Configuration registers.
  logic [RADIUS_BITS-1:0] radius;
  logic [CW-1:0]          center_u;
  logic [CW-1:0]          center_v;
  logic [CW-1:0]          min_u;
  logic [CW-1:0]          max_u;
  logic [CW-1:0]          min_v;
  logic [CW-1:0]          max_v;
  logic [START_BITS-1:0]  start_index;

  // Offset table: each entry holds a signed (du, dv) pair.
  logic [2*DW-1:0] mem [DEPTH];
  logic [2*DW-1:0] rd_data;
  logic            rd_en;

  // Build walker.
  logic signed [DW-1:0] r_eff;
  logic signed [DW-1:0] b_du;
  logic signed [DW-1:0] b_dv;
  logic signed [DW-1:0] du_abs;
  logic signed [DW-1:0] du_inc;
  logic signed [DW-1:0] inc_abs;
  logic signed [DW-1:0] lim;
  logic signed [DW-1:0] lim_inc;
  logic [IW-1:0]        table_size;

  // Scan state.
  logic [IW-1:0]  scan_offset;
  logic [IW-1:0]  mod_rem;
  logic [MCW-1:0] mod_cnt;
  logic [IW:0]    shifted;
  logic           shift_ge;
  logic [IW:0]    seed_sum;
  logic [IW:0]    seed_idx;
  logic [AW-1:0]  rd_idx;
  logic [IW-1:0]  rd_off;
  logic           chk_valid;
  logic [IW-1:0]  chk_off;
  logic           issue;
  logic           hit;
  logic           scan_end;

  logic signed [DW-1:0]  e_du;
  logic signed [DW-1:0]  e_dv;
  logic signed [SCW-1:0] su;
  logic signed [SCW-1:0] sv;
  logic                  in_window;

  logic                  res_found;
  logic [FIELD_BITS-1:0] res_u;
  logic [FIELD_BITS-1:0] res_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= '0;
      center_u    <= '0;
      center_v    <= '0;
      min_u       <= '0;
      max_u       <= CW'(FIELD_MASK);
      min_v       <= '0;
      max_v       <= CW'(FIELD_MASK);
      start_index <= '0;
    end else if (cmd.cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS:      radius      <= cfg_data[RADIUS_BITS-1:0];
        REG_CENTER_U:    center_u    <= CW'(cfg_data);
        REG_CENTER_V:    center_v    <= CW'(cfg_data);
        REG_MIN_U:       min_u       <= CW'(cfg_data);
        REG_MAX_U:       max_u       <= CW'(cfg_data);
        REG_MIN_V:       min_v       <= CW'(cfg_data);
        REG_MAX_V:       max_v       <= CW'(cfg_data);
        REG_START_INDEX: start_index <= cfg_data[START_BITS-1:0];
        default:         radius      <= radius;
      endcase
    end
  end

  // Radius beyond the table's reach saturates.
  assign r_eff   = (int'(radius) > RADIUS_CAP) ? DW'(RADIUS_CAP) : DW'(radius);
  assign du_abs  = b_du[DW-1] ? -b_du : b_du;
  assign du_inc  = b_du + DW'(1);
  assign inc_abs = du_inc[DW-1] ? -du_inc : du_inc;
  assign lim     = r_eff - du_abs;
  assign lim_inc = r_eff - inc_abs;

  assign shifted  = {mod_rem, start_index[mod_cnt]};
  assign shift_ge = (shifted >= {1'b0, table_size});
  assign seed_sum = {1'b0, mod_rem} + {1'b0, scan_offset};
  assign seed_idx = (seed_sum >= {1'b0, table_size}) ? (seed_sum - {1'b0, table_size})
                                                     : seed_sum;

  assign e_du      = rd_data[2*DW-1:DW];
  assign e_dv      = rd_data[DW-1:0];
  assign su        = $signed({2'b00, center_u}) + SCW'(e_du);
  assign sv        = $signed({2'b00, center_v}) + SCW'(e_dv);
  assign in_window = (su >= $signed({2'b00, min_u})) && (su < $signed({2'b00, max_u})) &&
                     (sv >= $signed({2'b00, min_v})) && (sv < $signed({2'b00, max_v}));

  assign issue    = (rd_off < table_size);
  assign hit      = chk_valid && in_window;
  assign scan_end = !chk_valid && !issue;
  assign rd_en    = cmd.scan_step && !hit && !scan_end && issue;

  assign stat.build_last = (b_du == r_eff) && (b_dv == lim);
  assign stat.mod_last   = (mod_cnt == '0);
  assign stat.scan_done  = hit || scan_end;
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.build_step) begin
      mem[table_size[AW-1:0]] <= {b_du, b_dv};
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_du        <= '0;
      b_dv        <= '0;
      table_size  <= '0;
      scan_offset <= '0;
      mod_rem     <= '0;
      mod_cnt     <= '0;
      rd_idx      <= '0;
      rd_off      <= '0;
      chk_valid   <= 1'b0;
      chk_off     <= '0;
    end else begin
      if (cmd.build_init) begin
        b_du        <= -r_eff;
        b_dv        <= '0;
        table_size  <= '0;
        scan_offset <= '0;
      end
      if (cmd.build_step) begin
        table_size <= table_size + IW'(1);
        if (b_dv == lim) begin
          b_du <= du_inc;
          b_dv <= -lim_inc;
        end else begin
          b_dv <= b_dv + DW'(1);
        end
      end
      if (cmd.accept) begin
        if (restart) scan_offset <= '0;
        mod_rem <= '0;
        mod_cnt <= MCW'(START_BITS - 1);
      end
      if (cmd.mod_step) begin
        mod_rem <= shift_ge ? IW'(shifted - {1'b0, table_size}) : shifted[IW-1:0];
        mod_cnt <= mod_cnt - MCW'(1);
      end
      if (cmd.seed) begin
        rd_idx    <= seed_idx[AW-1:0];
        rd_off    <= scan_offset;
        chk_valid <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (hit) begin
          scan_offset <= chk_off + IW'(1);
          chk_valid   <= 1'b0;
        end else if (scan_end) begin
          scan_offset <= rd_off;
        end else begin
          chk_valid <= issue;
          chk_off   <= rd_off;
          if (issue) begin
            rd_off <= rd_off + IW'(1);
            rd_idx <= (rd_idx == AW'(table_size - IW'(1))) ? '0 : rd_idx + AW'(1);
          end
        end
      end
    end
  end

  // Result capture; payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      if (hit) begin
        res_found <= 1'b1;
        res_u     <= FIELD_BITS'(su[CW-1:0]);
        res_v     <= FIELD_BITS'(sv[CW-1:0]);
      end else if (scan_end) begin
        res_found <= 1'b0;
        res_u     <= '0;
        res_v     <= '0;
      end
    end
    if (cmd.out_load) begin
      found  <= res_found;
      cell_u <= res_u;
      cell_v <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/diamond_neighbourhood_scanner_top.sv @@
// Requests are served one at a time: the start index is reduced modulo the table size,
// then the table scan examines one entry per cycle through the offset table memory's
// single read port.
// Reset, and every radius write, rebuild the offset table at one entry per cycle;
// during the rebuild no request and no configuration write is taken.
module diamond_neighbourhood_scanner_top import dns_pkg::*; #(
  parameter int RADIUS_CAP = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // Request channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     restart,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     found,
  output logic [FIELD_BITS-1:0]    cell_u,
  output logic [FIELD_BITS-1:0]    cell_v,
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // The controller sequences table build, start reduction, scan and result
  // delivery. It only talks to the datapath through these two structs.
  cmd_t  cmd;
  stat_t stat;

  // Requests are taken only in the idle state and only while no configuration
  // beat is offered. A finished result sits in the output register until its
  // beat is taken, and the next request may be accepted meanwhile; the scan
  // then waits at delivery until the slot frees.
  dns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath owns the registers, the offset table memory, the restoring
  // remainder unit for the start rotation and the two-stage read and check
  // pipeline of the scan.
  dns_datapath #(
    .RADIUS_CAP (RADIUS_CAP),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .found     (found),
    .cell_u    (cell_u),
    .cell_v    (cell_v)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import dns_pkg::*;

  // The block under test is built with its default parameters, so the scan
  // model here uses the same diamond bound.
  localparam int RADIUS_CAP  = 32;
  localparam int DIAMOND_MAX = 2 * RADIUS_CAP * RADIUS_CAP + 2 * RADIUS_CAP + 1;

  // Minimum number of random requests after the directed part.
  localparam int RANDOM_ITEMS = 258;

  // Worst case per request: a full radius-32 scan, a table rebuild after a radius
  // write, and sender gaps and receiver stalls. The limit covers three hundred
  // such requests three times over.
  localparam int CYCLE_LIMIT = 4_000_000;

  // One result beat as the block should present it.
  typedef struct packed {
    logic                  found;
    logic [FIELD_BITS-1:0] cell_u;
    logic [FIELD_BITS-1:0] cell_v;
  } cell_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_WAVE
  } stall_mode_t;

  // Scoreboard: keeps its own copy of the register file, the diamond walk order
  // and the scan position, predicts the cell for every accepted request and
  // checks result beats against those predictions in order.
  class scan_scoreboard;
    logic [RADIUS_BITS-1:0] radius;
    logic [FIELD_BITS-1:0]  center_u, center_v, min_u, max_u, min_v, max_v;
    logic [START_BITS-1:0]  start_index;
    int unsigned            scan_offset;
    int unsigned            diamond_size;
    logic signed [7:0]      step_u [DIAMOND_MAX];
    logic signed [7:0]      step_v [DIAMOND_MAX];
    cell_result_t           expected_cells [$];
    int unsigned            errors, checked, hits, misses, widest;

    function new();
      radius      = '0;
      center_u    = '0;
      center_v    = '0;
      min_u       = '0;
      max_u       = FIELD_MASK;
      min_v       = '0;
      max_v       = FIELD_MASK;
      start_index = '0;
      scan_offset = 0;
      errors      = 0;
      checked     = 0;
      hits        = 0;
      misses      = 0;
      widest      = 0;
      build_diamond();
    endfunction

    // Walk order is u ascending, then v ascending, over |du|+|dv| <= r.
    function void build_diamond();
      int r;
      r = (radius > RADIUS_CAP) ? RADIUS_CAP : int'(radius);
      if (r > widest) widest = r;
      diamond_size = 0;
      for (int du = -r; du <= r; du++) begin
        for (int dv = -r; dv <= r; dv++) begin
          if ((du < 0 ? -du : du) + (dv < 0 ? -dv : dv) <= r) begin
            step_u[diamond_size] = 8'(du);
            step_v[diamond_size] = 8'(dv);
            diamond_size++;
          end
        end
      end
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_RADIUS: begin
          radius = data[RADIUS_BITS-1:0];
          build_diamond();
          scan_offset = 0;
        end
        REG_CENTER_U:    center_u = data;
        REG_CENTER_V:    center_v = data;
        REG_MIN_U:       min_u = data;
        REG_MAX_U:       max_u = data;
        REG_MIN_V:       min_v = data;
        REG_MAX_V:       max_v = data;
        REG_START_INDEX: start_index = data[START_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Scans forward from the kept offset until a cell lands in the window.
    function void note_request(logic restart_req);
      cell_result_t next_cell;
      int unsigned  base, idx;
      int           su, sv;
      next_cell = '0;
      if (restart_req) scan_offset = 0;
      base = start_index % diamond_size;
      while (!next_cell.found && scan_offset < diamond_size) begin
        idx = (base + scan_offset) % diamond_size;
        su = int'(center_u) + int'(step_u[idx]);
        sv = int'(center_v) + int'(step_v[idx]);
        scan_offset++;
        if (su >= int'(min_u) && su < int'(max_u) &&
            sv >= int'(min_v) && sv < int'(max_v)) begin
          next_cell.found  = 1'b1;
          next_cell.cell_u = su[FIELD_BITS-1:0];
          next_cell.cell_v = sv[FIELD_BITS-1:0];
        end
      end
      expected_cells = {expected_cells, next_cell};
    endfunction

    function void report_field(string field, logic [FIELD_BITS-1:0] want,
                               logic [FIELD_BITS-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected 0x%04h, actual 0x%04h", $time, field,
               want, got);
    endfunction

    function void check_result(logic found_bit, logic [FIELD_BITS-1:0] u,
                               logic [FIELD_BITS-1:0] v);
      cell_result_t want;
      checked++;
      if (expected_cells.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual found=%0b u=0x%04h v=0x%04h",
                 $time, found_bit, u, v);
        return;
      end
      want = expected_cells.pop_front();
      if (want.found) hits++;
      else misses++;
      if (found_bit !== want.found) report_field("found", 16'(want.found), 16'(found_bit));
      if (u !== want.cell_u) report_field("cell_u", want.cell_u, u);
      if (v !== want.cell_v) report_field("cell_v", want.cell_v, v);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     restart;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     found;
  logic [FIELD_BITS-1:0]    cell_u;
  logic [FIELD_BITS-1:0]    cell_v;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  scan_scoreboard sb;
  stall_mode_t    stall_mode = STALL_NONE;
  int unsigned    cycle_count = 0;
  int unsigned    sent_count = 0;
  int unsigned    random_sent = 0;
  int unsigned    cfg_beats = 0;
  int unsigned    settings = 0;
  int             cur_radius = 0;

  diamond_neighbourhood_scanner_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .cell_u    (cell_u),
    .cell_v    (cell_v),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Watchdog. A hung handshake or a result that never comes ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results still outstanding.",
               cycle_count, sent_count - sb.checked);
      $display("[diamond_neighbourhood_scanner_top] ERROR");
      $finish;
    end
  end

  // The result side stalls on its own pattern, chosen per register setting:
  // never, on random cycles, or in long regular waves.
  always @(posedge clk) begin
    case (stall_mode)
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_WAVE:   out_stall <= ((cycle_count % 41) < 25);
      default:      out_stall <= 1'b0;
    endcase
  end

  // Monitors. All three sample the values that were present before the edge,
  // so they see exactly the beats that the block sees.
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      cfg_beats++;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_request(restart);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(found, cell_u, cell_v);
  end

  // One register write. The valid is left high so that back-to-back writes do
  // not drop it for a cycle; the caller lowers it after the last one.
  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_all(input logic [CFG_DATA_BITS-1:0] rad, cu, cv, minu, maxu,
                             minv, maxv, start);
    write_cfg(REG_RADIUS, rad);
    write_cfg(REG_CENTER_U, cu);
    write_cfg(REG_CENTER_V, cv);
    write_cfg(REG_MIN_U, minu);
    write_cfg(REG_MAX_U, maxu);
    write_cfg(REG_MIN_V, minv);
    write_cfg(REG_MAX_V, maxv);
    write_cfg(REG_START_INDEX, start);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // One request beat. Valid stays high on return so the next beat can follow
  // without a bubble.
  task automatic send_request(input logic rs);
    in_valid <= 1'b1;
    restart  <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Blocks until every accepted request has had its result beat.
  task automatic wait_drained();
    while (sb.checked < sent_count) @(posedge clk);
  endtask

  // Random bursts of requests with random gaps in between. Now and then the
  // sender holds off until everything it sent has come back.
  task automatic drive_burst(input int count, input int restart_pct);
    int run, gap;
    run = $urandom_range(1, 6);
    for (int i = 0; i < count; i++) begin
      send_request($urandom_range(0, 99) < restart_pct);
      run--;
      if ($urandom_range(0, 39) == 0) begin
        in_valid <= 1'b0;
        wait_drained();
      end else if (run == 0) begin
        gap = $urandom_range(0, 8);
        // A zero gap keeps valid high; lowering and raising it in the same
        // step would be order dependent.
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        run = $urandom_range(1, 6);
      end
    end
    in_valid <= 1'b0;
    random_sent += count;
  endtask

  // Picks a window on one axis: the whole map, anything at all, an empty
  // window, or (most often) one that clips the diamond around the center.
  function automatic void pick_window(input logic [FIELD_BITS-1:0] c, input int r,
                                      output logic [FIELD_BITS-1:0] lo,
                                      output logic [FIELD_BITS-1:0] hi);
    case ($urandom_range(0, 9))
      0, 1: begin
        lo = '0;
        hi = FIELD_MASK;
      end
      2: begin
        lo = 16'($urandom_range(0, 65535));
        hi = 16'($urandom_range(0, 65535));
      end
      3: begin
        lo = c;
        hi = c;
      end
      default: begin
        lo = c - 16'($urandom_range(0, r + 1));
        hi = c + 16'($urandom_range(0, r + 2));
      end
    endcase
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_center();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 40));
      1:       return FIELD_MASK - 16'($urandom_range(0, 40));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // A new random register setting. The radius is usually small so most scans
  // stay short; a few settings use the largest radius or one above it, which
  // the block saturates. Writes other than the radius keep the scan position,
  // so later requests may carry on from where the previous setting left off.
  task automatic random_setting();
    int                    pick, eff;
    logic [RADIUS_BITS-1:0] rad;
    logic [FIELD_BITS-1:0] cu, cv, minu, maxu, minv, maxv;
    if ($urandom_range(0, 99) < 60) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) rad = 6'($urandom_range(0, 6));
      else if (pick < 88) rad = 6'($urandom_range(7, 12));
      else rad = 6'($urandom_range(32, 63));
      write_cfg(REG_RADIUS, {10'($urandom_range(0, 1023)), rad});
      cur_radius = rad;
    end
    eff = (cur_radius > RADIUS_CAP) ? RADIUS_CAP : cur_radius;
    cu = pick_center();
    cv = pick_center();
    pick_window(cu, eff, minu, maxu);
    pick_window(cv, eff, minv, maxv);
    write_cfg(REG_CENTER_U, cu);
    write_cfg(REG_CENTER_V, cv);
    if ($urandom_range(0, 3) != 0) write_cfg(REG_MIN_U, minu);
    if ($urandom_range(0, 3) != 0) write_cfg(REG_MAX_U, maxu);
    if ($urandom_range(0, 3) != 0) write_cfg(REG_MIN_V, minv);
    if ($urandom_range(0, 3) != 0) write_cfg(REG_MAX_V, maxv);
    if ($urandom_range(0, 3) != 0)
      write_cfg(REG_START_INDEX, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    restart   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_RADIUS;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: radius 0 gives a one-cell diamond at the origin. The
    // second and third requests find it used up and report nothing found.
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Radius 1 around (100, 200): all five cells in walk order, then one
    // request past the end of the diamond.
    stall_mode = STALL_RANDOM;
    program_all(1, 100, 200, 0, 16'hFFFF, 0, 16'hFFFF, 0);
    send_request(1'b1);
    repeat (5) send_request(1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Center on the map corner u=0, v=0xFFFF: negative columns and rows at or
    // past the exclusive top bound are skipped. The start index is larger
    // than the diamond and wraps.
    stall_mode = STALL_WAVE;
    program_all(2, 0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 40);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Radius 40 saturates to the maximum. The window lets through only the
    // last cell of the walk, so the first request scans the whole diamond and
    // the next one finds it exhausted.
    stall_mode = STALL_NONE;
    program_all(40, 16'h8000, 16'h1234, 16'h8020, 16'h8021, 0, 16'hFFFF, 0);
    send_request(1'b1);
    send_request(1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // An empty column window: nothing is ever inside. Largest start index.
    program_all(3, 5, 5, 5, 5, 0, 16'hFFFF, 16'hFFF);
    send_request(1'b1);
    send_request(1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // A center write leaves the scan position alone; a radius write rewinds it.
    stall_mode = STALL_RANDOM;
    program_all(1, 10, 10, 0, 16'hFFFF, 0, 16'hFFFF, 16'hFFF);
    send_request(1'b1);
    send_request(1'b0);
    in_valid <= 1'b0;
    wait_drained();
    write_cfg(REG_CENTER_U, 20);
    cfg_valid <= 1'b0;
    send_request(1'b0);
    in_valid <= 1'b0;
    wait_drained();
    write_cfg(REG_RADIUS, 1);
    cfg_valid <= 1'b0;
    send_request(1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Random part: a new setting, a burst of requests, then drain before the
    // next setting is written. Large diamonds get few requests and few
    // restarts so their long scans do not dominate the run.
    while (random_sent < RANDOM_ITEMS) begin
      random_setting();
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      if (cur_radius > 12) drive_burst($urandom_range(3, 10), 10);
      else drive_burst($urandom_range(4, 24), 30);
      wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);

    $display("Covered %0d requests under %0d register settings (%0d config beats),",
             sent_count, settings, cfg_beats);
    $display("radius up to %0d; %0d returned a cell, %0d found the diamond used up; %0d mismatches.",
             sb.widest, sb.hits, sb.misses, sb.errors);
    if (sb.errors == 0 && sb.expected_cells.size() == 0) begin
      $display("[diamond_neighbourhood_scanner_top] OK");
    end else begin
      $display("[diamond_neighbourhood_scanner_top] ERROR");
    end
    $finish;
  end

endmodule
